// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the ARP cache responder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/arpc_pkg.sv -----
// Package with the shared types and constants of the ARP cache responder.
package arpc_pkg;

  localparam int IDX_W = 8;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] MIN_LEN = 16'd28;
  localparam logic [15:0] HW_ETHER = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [15:0] OP_FIELD_REQ = 16'h0001;

  localparam logic [1:0] REG_OWN_MAC = 2'd0;
  localparam logic [1:0] REG_OWN_IP = 2'd1;
  localparam logic [1:0] REG_IP_CFG = 2'd2;
  localparam logic [1:0] REG_NIC = 2'd3;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_HIT = 3'd1,
    ACT_MISS_REQ = 3'd2,
    ACT_MISS_NOREQ = 3'd3,
    ACT_REPLY = 3'd4
  } action_t;

  localparam logic [1:0] OPER_NONE = 2'd0;
  localparam logic [1:0] OPER_REQUEST = 2'd1;
  localparam logic [1:0] OPER_REPLY = 2'd2;

  localparam logic OPC_PACKET = 1'b0;
  localparam logic OPC_LOOKUP = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now;
    logic [15:0] frame_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] op_code_field;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] tgt_ip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] found_mac;
    logic [47:0] eth_dest_mac;
    logic [1:0]  pkt_oper;
    logic [47:0] pkt_sender_mac;
    logic [31:0] pkt_sender_ip;
    logic [47:0] pkt_target_mac;
    logic [31:0] pkt_target_ip;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      key;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [47:0]      hit_mac;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      best_time;
    logic [IDX_W-1:0] best_idx;
  } scan_rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [31:0]      ip;
    logic [47:0]      mac;
    logic [31:0]      stamp;
  } wr_t;

endpackage

// ----- hw/rtl/arp_cache_responder.sv -----
// Top level of the ARP cache responder: control, configuration and the cell chain.
// Each transaction is scanned through a chain of ENTRIES cells, one cell per cycle.
// A result is registered as the scan leaves the last cell and is then offered until taken.
// One transaction is in flight at a time: a new one is accepted only after the result is taken.
// The cache write for a well-formed packet happens in the cycle the scan leaves the last cell.
// Synchronous reset clears the state and configuration registers, all entry valid bits and timestamps.
`include "assert_macros.svh"
module arp_cache_responder #(
  parameter int ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  arpc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output arpc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [47:0]          cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [47:0]         own_mac;
  logic [31:0]         own_ip;
  logic                ip_configured;
  logic                nic_present;
  arpc_pkg::in_item_t  item;
  arpc_pkg::out_item_t res_next;
  arpc_pkg::scan_rec_t rec [ENTRIES+1];
  logic                tok [ENTRIES+1];
  arpc_pkg::wr_t       wr;
  logic                accept;
  logic                scan_done;
  logic                pkt_ok;
  arpc_pkg::scan_rec_t fin;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign tok[0] = accept;
  assign scan_done = tok[ENTRIES];
  assign fin = rec[ENTRIES];

  always_comb begin
    rec[0] = '0;
    rec[0].key = (in_data.opcode == arpc_pkg::OPC_PACKET) ? in_data.sender_ip
                                                          : in_data.tgt_ip;
    rec[0].best_time = '1;
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      arpc_cell #(.IDX(g)) u_cell (
        .clk    (clk),
        .rst    (rst),
        .tok_in (tok[g]),
        .rec_in (rec[g]),
        .wr     (wr),
        .tok_out(tok[g+1]),
        .rec_out(rec[g+1])
      );
    end
  endgenerate

  assign pkt_ok = (item.frame_len >= arpc_pkg::MIN_LEN) &&
                  (item.hw_type == arpc_pkg::HW_ETHER) &&
                  (item.proto_type == arpc_pkg::PROTO_IPV4);

  always_comb begin
    wr = '0;
    wr.ip = item.sender_ip;
    wr.mac = item.sender_mac;
    wr.stamp = item.now;
    wr.we = scan_done && (item.opcode == arpc_pkg::OPC_PACKET) && pkt_ok;
    if (fin.hit) begin
      wr.idx = fin.hit_idx;
    end else if (fin.free) begin
      wr.idx = fin.free_idx;
    end else begin
      wr.idx = fin.best_idx;
    end
  end

  always_comb begin
    res_next = '0;
    if (item.opcode == arpc_pkg::OPC_PACKET) begin
      if (pkt_ok && (item.op_code_field == arpc_pkg::OP_FIELD_REQ) &&
          ip_configured && (item.tgt_ip == own_ip)) begin
        res_next.action = arpc_pkg::ACT_REPLY;
        res_next.eth_dest_mac = item.sender_mac;
        res_next.pkt_oper = arpc_pkg::OPER_REPLY;
        res_next.pkt_sender_mac = own_mac;
        res_next.pkt_sender_ip = own_ip;
        res_next.pkt_target_mac = item.sender_mac;
        res_next.pkt_target_ip = item.sender_ip;
      end else begin
        res_next.action = arpc_pkg::ACT_NONE;
        res_next.pkt_oper = arpc_pkg::OPER_NONE;
      end
    end else if (fin.hit) begin
      res_next.action = arpc_pkg::ACT_HIT;
      res_next.found_mac = fin.hit_mac;
    end else if (nic_present) begin
      res_next.action = arpc_pkg::ACT_MISS_REQ;
      res_next.eth_dest_mac = arpc_pkg::BCAST_MAC;
      res_next.pkt_oper = arpc_pkg::OPER_REQUEST;
      res_next.pkt_sender_mac = own_mac;
      res_next.pkt_sender_ip = own_ip;
      res_next.pkt_target_ip = item.tgt_ip;
    end else begin
      res_next.action = arpc_pkg::ACT_MISS_NOREQ;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (scan_done) state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      own_mac <= '0;
      own_ip <= '0;
      ip_configured <= 1'b0;
      nic_present <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          arpc_pkg::REG_OWN_MAC: own_mac <= cfg_data;
          arpc_pkg::REG_OWN_IP:  own_ip <= cfg_data[31:0];
          arpc_pkg::REG_IP_CFG:  ip_configured <= cfg_data[0];
          arpc_pkg::REG_NIC:     nic_present <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (scan_done) begin
      out_data <= res_next;
    end
  end

  `ASSERT_NEXT(a_accept_scan, clk, rst, accept, state == ST_SCAN)
  `ASSERT_NEXT(a_done_result, clk, rst, scan_done, out_valid)
  `ASSERT_IMPL(a_write_in_scan, clk, rst, wr.we, state == ST_SCAN)
  `ASSERT_IMPL(a_one_in_flight, clk, rst, in_ready, !out_valid)

endmodule

// ----- hw/rtl/arpc_cell.sv -----
// One cache entry cell that updates the passing scan record and hands it on.
module arpc_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_in,
  input  arpc_pkg::scan_rec_t rec_in,
  input  arpc_pkg::wr_t       wr,
  output logic                tok_out,
  output arpc_pkg::scan_rec_t rec_out
);

  logic                valid;
  logic [31:0]         ip;
  logic [47:0]         mac;
  logic [31:0]         stamp;
  arpc_pkg::scan_rec_t rec_next;
  logic                sel;

  assign sel = wr.we && (wr.idx == arpc_pkg::IDX_W'(IDX));

  always_comb begin
    rec_next = rec_in;
    if (!rec_in.hit && valid && (ip == rec_in.key)) begin
      rec_next.hit = 1'b1;
      rec_next.hit_idx = arpc_pkg::IDX_W'(IDX);
      rec_next.hit_mac = mac;
    end
    if (!rec_in.free && !valid) begin
      rec_next.free = 1'b1;
      rec_next.free_idx = arpc_pkg::IDX_W'(IDX);
    end
    if (stamp < rec_in.best_time) begin
      rec_next.best_time = stamp;
      rec_next.best_idx = arpc_pkg::IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      stamp <= '0;
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (sel) begin
        valid <= 1'b1;
        stamp <= wr.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      ip <= wr.ip;
      mac <= wr.mac;
    end
    rec_out <= rec_next;
  end

endmodule
